// ===== rtl/eaptls_pkg.sv =====
// Shared types and constants of the EAP-TLS fragment reassembler.
package eaptls_pkg;

	// Packet verdicts, also used as the stored header error code (VERD_ACK means no error)
	typedef enum logic [3:0] {
		VERD_ACK        = 4'd0,
		VERD_COMPLETE   = 4'd1,
		VERD_EMPTY      = 4'd2,
		VERD_START      = 4'd3,
		VERD_SHORT      = 4'd4,
		VERD_PKTLEN     = 4'd5,
		VERD_MSGLEN     = 4'd6,
		VERD_UNEXPECTED = 4'd7,
		VERD_OVERFLOW   = 4'd8,
		VERD_INCOMPLETE = 4'd9,
		VERD_COUNT      = 4'd10
	} verdict_t;

	// Configuration register indexes
	localparam logic [1:0] CFG_SERVER_ROLE   = 2'd0;
	localparam logic [1:0] CFG_PACKET_LIMIT  = 2'd1;
	localparam logic [1:0] CFG_MESSAGE_LIMIT = 2'd2;

	localparam logic [7:0]  PACKET_LIMIT_RST  = 8'd16;
	localparam logic [14:0] MESSAGE_LIMIT_RST = 15'd16384;

	// Bit positions in the flags byte
	localparam int FLAG_L = 7;
	localparam int FLAG_M = 6;
	localparam int FLAG_S = 5;

	localparam logic [15:0] HDR_BASE = 16'd6;
	localparam logic [15:0] HDR_EXT  = 16'd10;

	typedef struct packed {
		logic        item_kind;
		logic [7:0]  payload_byte;
		logic [13:0] payload_offset;
		verdict_t    verdict;
		logic [7:0]  reply_identifier;
		logic [14:0] message_length;
		logic [2:0]  tls_version;
	} res_t;

	// Up to two results caused by one byte: a payload byte, then a verdict
	typedef struct packed {
		logic pay_v;
		res_t pay;
		logic ver_v;
		res_t ver;
	} res_pair_t;

endpackage

// ===== rtl/eap_tls_fragment_reassembler.sv =====
// Top level of the EAP-TLS fragment reassembler: input register, parser and result buffer.
// An accepted byte is held in the input register, then its results are loaded into the result buffer that drives m_*.
// Throughput: one byte per cycle while m_tready holds no result back; a packet's final byte that also carries a payload
// byte takes two output transfers, one per result.
// Reset: arst_n clears all reassembly state, the packet count and the configuration
// registers (server_role 0, packet_limit 16, message_limit 16384) at once.
module eap_tls_fragment_reassembler #(
	parameter int MAX_MESSAGE_BYTES = 16384
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte[7:0]
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	// payload_byte[7:0], payload_offset[21:8], verdict[25:22], reply_identifier[33:26],
	// message_length[48:34], tls_version[51:49], zero[55:52]
	output logic [55:0] m_tdata,
	output logic        m_tuser,   // item_kind[0]
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [14:0] cfg_data
);
	import eaptls_pkg::*;

	logic        role_q;
	logic [7:0]  plimit_q;
	logic [14:0] mlimit_q;

	logic        valid_s1, last_s1;
	logic [7:0]  byte_s1;
	logic        ob_ready, step;
	res_pair_t   pair;
	res_t        res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			role_q   <= 1'b0;
			plimit_q <= PACKET_LIMIT_RST;
			mlimit_q <= MESSAGE_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SERVER_ROLE:   role_q   <= cfg_data[0];
				CFG_PACKET_LIMIT:  plimit_q <= cfg_data[7:0];
				CFG_MESSAGE_LIMIT: mlimit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign step     = valid_s1 & ob_ready;
	assign s_tready = !valid_s1 || ob_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	eaptls_parser #(
		.MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
	) u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.data_byte     (byte_s1),
		.packet_end    (last_s1),
		.server_role   (role_q),
		.packet_limit  (plimit_q),
		.message_limit (mlimit_q),
		.results       (pair)
	);

	eaptls_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (step),
		.in_pair  (pair),
		.ready    (ob_ready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.res      (res)
	);

	assign m_tuser = res.item_kind;
	assign m_tdata = {4'b0000, res.tls_version, res.message_length, res.reply_identifier,
		res.verdict, res.payload_offset, res.payload_byte};
endmodule

// ===== rtl/eaptls_parser.sv =====
// Header parser, reassembly state and verdict logic, one byte per step.
module eaptls_parser #(
	parameter int MAX_MESSAGE_BYTES = 16384
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            data_byte,
	input  logic                  packet_end,
	input  logic                  server_role,
	input  logic [7:0]            packet_limit,
	input  logic [14:0]           message_limit,
	output eaptls_pkg::res_pair_t results
);
	import eaptls_pkg::*;

	localparam logic [16:0] MaxBytes = 17'(MAX_MESSAGE_BYTES);

	logic [15:0] rcnt_q, rcnt_n;
	logic [7:0]  id_q, id_n;
	logic [15:0] dlen_q, dlen_n;
	logic [7:0]  flags_q, flags_n;
	verdict_t    err_q, err_n;
	logic        big_q, big_n;
	logic [7:0]  lhi_q, lhi_n;
	logic [14:0] exp_q, exp_n;
	logic        act_q, act_n;
	logic [14:0] wp_q, wp_n;
	logic [7:0]  pcnt_q, pcnt_n;

	logic        is_start, lpath, lt, gt, clr;
	logic [15:0] hdr_q, hdr_n, room_q, room_new, pdl_l, pdl_n, lf16, off16;
	logic [16:0] lim, sum17;
	verdict_t    v;
	logic [2:0]  ver;

	always_comb begin
		is_start = flags_q[FLAG_S];
		hdr_q    = flags_q[FLAG_L] ? HDR_EXT : HDR_BASE;
		lpath    = flags_q[FLAG_L] && !is_start && (dlen_q >= HDR_EXT);
		room_q   = {1'b0, exp_q} - {1'b0, wp_q};
		pdl_l    = dlen_q - HDR_EXT;
		lf16     = {lhi_q, data_byte};
		lim      = ({2'b00, message_limit} > MaxBytes) ? MaxBytes : {2'b00, message_limit};
		lt       = !big_q && (lf16 < pdl_l);
		gt       = big_q || ({1'b0, lf16} > lim);
		room_new = act_q ? room_q : {1'b0, lf16[14:0]};
		off16    = {1'b0, wp_q} + (rcnt_q - hdr_q);

		rcnt_n  = (rcnt_q == 16'hFFFF) ? rcnt_q : rcnt_q + 16'd1;
		id_n    = id_q;
		dlen_n  = dlen_q;
		flags_n = flags_q;
		err_n   = err_q;
		big_n   = big_q;
		lhi_n   = lhi_q;
		exp_n   = exp_q;
		act_n   = act_q;
		wp_n    = wp_q;
		pcnt_n  = pcnt_q;

		results = '0;

		if (rcnt_q < HDR_BASE) begin
			case (rcnt_q[2:0])
				3'd1: id_n = data_byte;
				3'd2: dlen_n = {data_byte, 8'h00};
				3'd3: dlen_n = {dlen_q[15:8], data_byte};
				3'd5: begin
					flags_n = data_byte;
					if (!data_byte[FLAG_S]) begin
						if (data_byte[FLAG_L]) begin
							if (dlen_q < HDR_EXT) err_n = VERD_SHORT;
						end else if (dlen_q > HDR_BASE && (dlen_q - HDR_BASE) > room_q) begin
							err_n = VERD_OVERFLOW;
						end
					end
				end
				default: ;
			endcase
		end else if (rcnt_q < HDR_EXT && lpath) begin
			case (rcnt_q[3:0]) inside
				4'd6, 4'd7: big_n = big_q | (data_byte != 8'h00);
				4'd8: lhi_n = data_byte;
				4'd9: begin
					if (lt || gt) begin
						err_n = VERD_MSGLEN;
					end else if (act_q && lf16 != {1'b0, exp_q}) begin
						err_n = VERD_UNEXPECTED;
					end else begin
						// The first fragment with a length opens a new message
						if (!act_q) begin
							exp_n = lf16[14:0];
							wp_n  = '0;
							act_n = 1'b1;
						end
						if (pdl_l > room_new) err_n = VERD_OVERFLOW;
					end
				end
				default: ;
			endcase
		end else if (!is_start && err_q == VERD_ACK && rcnt_q >= hdr_q && rcnt_q < dlen_q) begin
			results.pay_v                = 1'b1;
			results.pay.item_kind        = 1'b0;
			results.pay.payload_byte     = data_byte;
			results.pay.payload_offset   = off16[13:0];
			results.pay.message_length   = exp_q;
		end

		hdr_n = flags_n[FLAG_L] ? HDR_EXT : HDR_BASE;
		pdl_n = dlen_n - hdr_n;
		sum17 = {2'b00, wp_n} + {1'b0, pdl_n};
		clr   = 1'b1;
		ver   = '0;
		if (pcnt_q != 8'hFF) pcnt_n = pcnt_q + 8'd1;
		if (pcnt_n > packet_limit) begin
			v = VERD_COUNT;
		end else if (rcnt_n < HDR_BASE || dlen_n != rcnt_n) begin
			v = VERD_PKTLEN;
		end else if (flags_n[FLAG_S]) begin
			v   = VERD_START;
			ver = flags_n[2:0];
			clr = 1'b0;
		end else if (rcnt_n == HDR_BASE) begin
			v   = VERD_EMPTY;
			clr = 1'b0;
		end else if (err_n != VERD_ACK) begin
			v = err_n;
		end else if (flags_n[FLAG_M]) begin
			v   = VERD_ACK;
			clr = 1'b0;
		end else if (sum17 != {2'b00, exp_n}) begin
			v = VERD_INCOMPLETE;
		end else begin
			v = VERD_COMPLETE;
		end

		if (packet_end) begin
			results.ver_v                  = 1'b1;
			results.ver.item_kind          = 1'b1;
			results.ver.verdict            = v;
			results.ver.reply_identifier   = id_n + {7'b0, server_role};
			results.ver.message_length     = exp_n;
			results.ver.tls_version        = ver;
			if (clr) begin
				exp_n = '0;
				act_n = 1'b0;
				wp_n  = '0;
			end else if (v == VERD_ACK) begin
				wp_n = sum17[14:0];
			end
			rcnt_n  = '0;
			id_n    = '0;
			dlen_n  = '0;
			flags_n = '0;
			err_n   = VERD_ACK;
			big_n   = 1'b0;
			lhi_n   = '0;
		end else begin
			pcnt_n = pcnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcnt_q  <= '0;
			id_q    <= '0;
			dlen_q  <= '0;
			flags_q <= '0;
			err_q   <= VERD_ACK;
			big_q   <= 1'b0;
			lhi_q   <= '0;
			exp_q   <= '0;
			act_q   <= 1'b0;
			wp_q    <= '0;
			pcnt_q  <= '0;
		end else if (step) begin
			rcnt_q  <= rcnt_n;
			id_q    <= id_n;
			dlen_q  <= dlen_n;
			flags_q <= flags_n;
			err_q   <= err_n;
			big_q   <= big_n;
			lhi_q   <= lhi_n;
			exp_q   <= exp_n;
			act_q   <= act_n;
			wp_q    <= wp_n;
			pcnt_q  <= pcnt_n;
		end
	end

`ifndef SYNTHESIS
	a_wp_within_msg: assert property (@(posedge clk) disable iff (!arst_n)
		wp_q <= exp_q)
		else $error("write position beyond expected message length");
	a_idle_msg_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!act_q |-> (exp_q == '0 && wp_q == '0))
		else $error("inactive reassembly holds stale length or position");
	a_pcnt_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		pcnt_q >= $past(pcnt_q))
		else $error("packet count went backwards");
`endif
endmodule

// ===== rtl/eaptls_out_buf.sv =====
// Result buffer that holds the results of one byte and hands them out in order.
module eaptls_out_buf (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  eaptls_pkg::res_pair_t in_pair,
	output logic                  ready,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output eaptls_pkg::res_t      res
);
	import eaptls_pkg::*;

	logic pay_v_q, ver_v_q;
	res_t pay_q, ver_q;
	logic take;

	assign m_tvalid = pay_v_q | ver_v_q;
	assign take     = m_tvalid & m_tready;
	// Free for the next byte once the last pending result leaves in this cycle
	assign ready    = !m_tvalid || (take && !(pay_v_q && ver_v_q));
	assign res      = pay_v_q ? pay_q : ver_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pay_v_q <= 1'b0;
			ver_v_q <= 1'b0;
		end else if (load) begin
			pay_v_q <= in_pair.pay_v;
			ver_v_q <= in_pair.ver_v;
		end else if (take) begin
			if (pay_v_q) pay_v_q <= 1'b0;
			else ver_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pay_q <= in_pair.pay;
			ver_q <= in_pair.ver;
		end
	end

`ifndef SYNTHESIS
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> ready)
		else $error("result buffer overwritten while results pending");
	a_verdict_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(pay_v_q && ver_v_q && take && !load) |=> (!pay_v_q && ver_v_q))
		else $error("verdict lost after payload transfer");
`endif
endmodule

// ===== bench/eap_tls_fragment_reassembler_test.sv =====
// Self-checking testbench of the EAP-TLS fragment reassembler with its own reassembly predictor.
`timescale 1ns / 100ps

module eap_tls_fragment_reassembler_test;
	import eaptls_pkg::*;

	localparam int          MAX_MSG        = 16384;
	localparam int unsigned RX_HOLD_CYCLES = 300;
	localparam int unsigned DRAIN_CYCLES   = 4;
	localparam int unsigned QUIET_LIMIT    = 3000;

	// Byte positions within the fixed header
	localparam logic [15:0] POS_ID     = 16'd1;
	localparam logic [15:0] POS_LEN_HI = 16'd2;
	localparam logic [15:0] POS_LEN_LO = 16'd3;
	localparam logic [15:0] POS_FLAGS  = 16'd5;

	typedef struct packed {
		logic       last;
		logic [7:0] data;
	} link_byte_t;

	typedef enum {MSG_GOOD, MSG_ABANDON, MSG_BAD_TAIL} msg_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic        m_tuser;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = CFG_SERVER_ROLE;
	logic [14:0] cfg_data = 15'd0;

	eap_tls_fragment_reassembler #(.MAX_MESSAGE_BYTES(MAX_MSG)) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Predictor copy of configuration and reassembly state
	logic        role_q;
	logic [7:0]  pkt_limit_q;
	logic [14:0] msg_limit_q;
	logic [7:0]  rx_id;
	logic [15:0] rx_decl_len;
	logic [7:0]  rx_flags;
	logic [15:0] rx_count;
	logic [31:0] rx_len_field;
	verdict_t    rx_err;
	logic [14:0] msg_len;
	logic        msg_active;
	logic [14:0] wr_pos;
	logic [7:0]  pkt_count;

	res_t        expected_results[$];
	link_byte_t  tx_bytes[$];
	link_byte_t  tx_next;
	int unsigned phase_bytes;
	int unsigned mismatches = 0;
	int unsigned tx_idle_pct = 17;
	int unsigned rx_idle_pct = 85;
	int unsigned hold_req = 0;
	int unsigned hold_seen;
	int unsigned hold_left;
	int unsigned quiet_cycles;

	task automatic clear_packet_state();
		rx_id        = 8'd0;
		rx_decl_len  = 16'd0;
		rx_flags     = 8'd0;
		rx_count     = 16'd0;
		rx_len_field = 32'd0;
		rx_err       = VERD_ACK;
	endtask

	// Works out the results that one accepted byte causes
	task automatic reassemble_byte(input logic [7:0] b, input logic last);
		logic [15:0] idx;
		logic        is_start;
		logic        ext_len;
		logic [15:0] hdr_len;
		logic [15:0] body_len;
		logic [15:0] offs;
		logic [14:0] lim;
		logic        keep;
		verdict_t    v;
		res_t        r;
		idx      = rx_count;
		is_start = rx_flags[FLAG_S];
		ext_len  = rx_flags[FLAG_L] && !is_start && rx_decl_len >= HDR_EXT;
		hdr_len  = rx_flags[FLAG_L] ? HDR_EXT : HDR_BASE;
		lim      = (msg_limit_q > MAX_MSG) ? 15'(MAX_MSG) : msg_limit_q;
		if (rx_count != 16'hFFFF)
			rx_count = rx_count + 16'd1;

		if (idx < HDR_BASE) begin
			if (idx == POS_ID) begin
				rx_id = b;
			end else if (idx == POS_LEN_HI) begin
				rx_decl_len = {b, 8'h00};
			end else if (idx == POS_LEN_LO) begin
				rx_decl_len[7:0] = b;
			end else if (idx == POS_FLAGS) begin
				rx_flags = b;
				if (!b[FLAG_S]) begin
					if (b[FLAG_L]) begin
						if (rx_decl_len < HDR_EXT)
							rx_err = VERD_SHORT;
					end else if (rx_decl_len > HDR_BASE &&
							rx_decl_len - HDR_BASE > msg_len - wr_pos) begin
						rx_err = VERD_OVERFLOW;
					end
				end
			end
		end else if (idx < HDR_EXT && ext_len) begin
			rx_len_field = {rx_len_field[23:0], b};
			if (idx == HDR_EXT - 16'd1) begin
				body_len = rx_decl_len - HDR_EXT;
				if (rx_len_field < body_len || rx_len_field > lim) begin
					rx_err = VERD_MSGLEN;
				end else if (msg_active && rx_len_field != msg_len) begin
					rx_err = VERD_UNEXPECTED;
				end else begin
					if (!msg_active) begin
						msg_len    = rx_len_field[14:0];
						wr_pos     = 15'd0;
						msg_active = 1'b1;
					end
					if (body_len > msg_len - wr_pos)
						rx_err = VERD_OVERFLOW;
				end
			end
		end else if (!is_start && rx_err == VERD_ACK && idx >= hdr_len && idx < rx_decl_len) begin
			offs             = wr_pos + (idx - hdr_len);
			r                = '0;
			r.payload_byte   = b;
			r.payload_offset = offs[13:0];
			r.message_length = msg_len;
			expected_results.push_back(r);
		end

		if (last) begin
			keep = 1'b0;
			r    = '0;
			if (pkt_count != 8'hFF)
				pkt_count = pkt_count + 8'd1;
			r.item_kind        = 1'b1;
			r.reply_identifier = rx_id + {7'd0, role_q};
			r.message_length   = msg_len;
			if (pkt_count > pkt_limit_q) begin
				v = VERD_COUNT;
			end else if (rx_count < HDR_BASE || rx_decl_len != rx_count) begin
				v = VERD_PKTLEN;
			end else if (rx_flags[FLAG_S]) begin
				v             = VERD_START;
				r.tls_version = rx_flags[2:0];
				keep          = 1'b1;
			end else if (rx_count == HDR_BASE) begin
				v    = VERD_EMPTY;
				keep = 1'b1;
			end else if (rx_err != VERD_ACK) begin
				v = rx_err;
			end else begin
				body_len = rx_decl_len - hdr_len;
				if (rx_flags[FLAG_M]) begin
					v      = VERD_ACK;
					keep   = 1'b1;
					wr_pos = wr_pos + body_len[14:0];
				end else if (wr_pos + body_len != msg_len) begin
					v = VERD_INCOMPLETE;
				end else begin
					v = VERD_COMPLETE;
				end
			end
			r.verdict = v;
			expected_results.push_back(r);
			if (!keep) begin
				msg_len    = 15'd0;
				msg_active = 1'b0;
				wr_pos     = 15'd0;
			end
			clear_packet_state();
		end
	endtask

	task automatic compare_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	task automatic check_result(input logic kind, input logic [55:0] d);
		res_t want;
		if (expected_results.size() == 0) begin
			$display("%0t: result with none expected, expected nothing, actual kind %0d data %h",
				$time, kind, d);
			mismatches++;
		end else begin
			want = expected_results.pop_front();
			compare_field("item_kind", want.item_kind, kind);
			compare_field("payload_byte", want.payload_byte, d[7:0]);
			compare_field("payload_offset", want.payload_offset, d[21:8]);
			compare_field("verdict", want.verdict, d[25:22]);
			compare_field("reply_identifier", want.reply_identifier, d[33:26]);
			compare_field("message_length", want.message_length, d[48:34]);
			compare_field("tls_version", want.tls_version, d[51:49]);
		end
	endtask

	// Sender: holds each transfer until accepted, then maybe idles before the next
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= 8'd0;
			s_tlast  <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				reassemble_byte(s_tdata, s_tlast);
			if (!s_tvalid || s_tready) begin
				if (tx_bytes.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					tx_next = tx_bytes.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= tx_next.data;
					s_tlast  <= tx_next.last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each transfer; a hold-off request keeps tready low for a long stretch
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready  <= 1'b0;
			hold_left <= 0;
			hold_seen <= 0;
		end else begin
			if (m_tvalid && m_tready)
				check_result(m_tuser, m_tdata);
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				m_tready  <= 1'b0;
			end else if (hold_seen != hold_req) begin
				hold_seen <= hold_req;
				hold_left <= RX_HOLD_CYCLES;
				m_tready  <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == QUIET_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	task automatic push_byte(input logic [7:0] b, input logic last);
		link_byte_t item;
		item.data = b;
		item.last = last;
		tx_bytes.push_back(item);
		phase_bytes++;
	endtask

	// One packet: header, optional length field, body; skew puts the declared length off
	task automatic push_packet(input logic [7:0] flags, input logic ext,
			input logic [31:0] len_field, input int unsigned body, input int skew);
		int unsigned total;
		logic [15:0] decl;
		logic [7:0]  b;
		total = 6 + (ext ? 4 : 0) + body;
		decl  = 16'(int'(total) + skew);
		for (int i = 0; i < total; i++) begin
			case (i) inside
				2: b = decl[15:8];
				3: b = decl[7:0];
				4: b = ($urandom_range(3) == 0) ? 8'($urandom) : 8'd13;
				5: b = flags;
				6, 7, 8, 9: b = ext ? len_field[8 * (9 - i) +: 8] : 8'($urandom);
				default: b = 8'($urandom);
			endcase
			push_byte(b, i == total - 1);
		end
	endtask

	// A message split into fragments, optionally cut short or with a wrong final size
	task automatic push_message(input int unsigned len, input msg_mode_t mode);
		int unsigned sent;
		int unsigned chunk;
		int unsigned frag;
		logic        first;
		logic        more;
		logic [4:0]  low;
		logic [7:0]  flags;
		sent  = 0;
		first = 1'b1;
		frag  = $urandom_range(16, 1);
		do begin
			chunk = $urandom_range(frag, 1);
			if (chunk > len - sent)
				chunk = len - sent;
			more = (sent + chunk < len);
			if (!more && mode == MSG_BAD_TAIL) begin
				if (chunk > 0 && $urandom_range(1) == 0)
					chunk = chunk - 1;
				else
					chunk = chunk + 1;
			end
			low   = 5'($urandom);
			flags = {first || $urandom_range(7) == 0, more, 1'b0, low};
			push_packet(flags, flags[FLAG_L], len, chunk, 0);
			sent  = sent + chunk;
			first = 1'b0;
			if (more && mode == MSG_ABANDON && $urandom_range(1) == 0)
				return;
		end while (sent < len);
	endtask

	task automatic push_random_event();
		int unsigned sel;
		int unsigned lim;
		int unsigned cap;
		int unsigned n;
		int unsigned body;
		int          skew;
		logic [4:0]  low;
		logic [31:0] bad_len;
		sel  = $urandom_range(99);
		lim  = (msg_limit_q > MAX_MSG) ? MAX_MSG : msg_limit_q;
		cap  = ($urandom_range(19) == 0) ? 300 : 40;
		cap  = (lim < cap) ? lim : cap;
		low  = 5'($urandom);
		if (sel < 55) begin
			push_message($urandom_range(cap), MSG_GOOD);
		end else if (sel < 62) begin
			push_message($urandom_range(cap), $urandom_range(1) ? MSG_ABANDON : MSG_BAD_TAIL);
		end else if (sel < 69) begin
			// start packets may carry L and M too; both are ignored
			push_packet({1'($urandom), 1'($urandom), 1'b1, low}, 1'b0, 32'd0,
				$urandom_range(4), 0);
		end else if (sel < 75) begin
			push_packet({1'($urandom), 1'($urandom), 1'b0, low}, 1'b0, 32'd0, 0, 0);
		end else if (sel < 80) begin
			push_packet({1'b1, 1'($urandom), 1'b0, low}, 1'b0, 32'd0, $urandom_range(3), 0);
		end else if (sel < 85) begin
			body = $urandom_range(6);
			n    = 6 + body;
			if ($urandom_range(3) == 0)
				skew = 65535 - int'(n);
			else
				skew = $urandom_range(1) ? int'($urandom_range(3, 1)) : -int'($urandom_range(3, 1));
			push_packet({1'b0, 1'($urandom), 1'($urandom), low}, 1'b0, 32'd0, body, skew);
		end else if (sel < 88) begin
			n = $urandom_range(5, 1);
			for (int i = 0; i < n; i++)
				push_byte(8'($urandom), i == n - 1);
		end else if (sel < 93) begin
			body = $urandom_range(4, 1);
			case ($urandom_range(2))
				0: bad_len = $urandom_range(body - 1);
				1: bad_len = lim + 1 + $urandom_range(20000);
				default: bad_len = $urandom;
			endcase
			push_packet({1'b1, 1'($urandom), 1'b0, low}, 1'b1, bad_len, body, 0);
		end else if (sel < 96) begin
			push_packet({1'b0, 1'($urandom), 1'b0, low}, 1'b0, 32'd0, $urandom_range(8, 1), 0);
		end else begin
			n = $urandom_range(12, 1);
			for (int i = 0; i < n; i++)
				push_byte(8'($urandom), i == n - 1 || $urandom_range(3) == 0);
		end
	endtask

	task automatic run_random(input int unsigned budget);
		phase_bytes = 0;
		while (phase_bytes < budget)
			push_random_event();
	endtask

	// Waits until every queued byte went in and every expected result came out
	task automatic wait_drained();
		do
			@(posedge clk);
		while (tx_bytes.size() != 0 || s_tvalid || expected_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			CFG_SERVER_ROLE:   role_q      = val[0];
			CFG_PACKET_LIMIT:  pkt_limit_q = val[7:0];
			CFG_MESSAGE_LIMIT: msg_limit_q = val;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		role_q      = 1'b0;
		pkt_limit_q = PACKET_LIMIT_RST;
		msg_limit_q = MESSAGE_LIMIT_RST;
		msg_len     = 15'd0;
		msg_active  = 1'b0;
		wr_pos      = 15'd0;
		pkt_count   = 8'd0;
		clear_packet_state();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Truncated packet, start with every version bit, then a two-fragment message
		push_byte(8'hFF, 1'b1);
		push_byte(8'h01, 1'b0); push_byte(8'hFF, 1'b0); push_byte(8'h00, 1'b0);
		push_byte(8'h06, 1'b0); push_byte(8'h0D, 1'b0); push_byte(8'hA7, 1'b1);
		push_byte(8'h01, 1'b0); push_byte(8'h02, 1'b0); push_byte(8'h00, 1'b0);
		push_byte(8'h0B, 1'b0);
		push_byte(8'h0D, 1'b0); push_byte(8'hC0, 1'b0); push_byte(8'h00, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h00, 1'b0); push_byte(8'h02, 1'b0); push_byte(8'hFF, 1'b1);
		push_byte(8'h01, 1'b0); push_byte(8'h03, 1'b0); push_byte(8'h00, 1'b0);
		push_byte(8'h07, 1'b0);
		push_byte(8'h0D, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b1);
		wait_drained();

		// Packet limit just above the count so far, so the count verdict shows up
		write_reg(CFG_SERVER_ROLE, 15'd1);
		write_reg(CFG_PACKET_LIMIT, {7'd0, pkt_count} + 15'd4);
		write_reg(CFG_MESSAGE_LIMIT, 15'd100);
		run_random(150);
		wait_drained();

		write_reg(CFG_SERVER_ROLE, 15'd0);
		write_reg(CFG_PACKET_LIMIT, 15'd255);
		write_reg(CFG_MESSAGE_LIMIT, 15'd16384);
		run_random(400);
		hold_req <= hold_req + 1;
		wait_drained();

		tx_idle_pct <= 85;
		rx_idle_pct <= 17;
		write_reg(CFG_SERVER_ROLE, 15'd1);
		write_reg(CFG_MESSAGE_LIMIT, 15'd1);
		run_random(200);
		wait_drained();

		// Above the build maximum, so the maximum applies
		write_reg(CFG_MESSAGE_LIMIT, 15'h7FFF);
		run_random(350);
		wait_drained();

		tx_idle_pct <= 0;
		rx_idle_pct <= 0;
		write_reg(CFG_SERVER_ROLE, 15'd0);
		write_reg(CFG_MESSAGE_LIMIT, 15'd600);
		run_random(300);
		wait_drained();

		write_reg(CFG_PACKET_LIMIT, 15'd1);
		run_random(60);
		wait_drained();

		repeat (8) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/eaptls_pkg.sv
rtl/eaptls_parser.sv
rtl/eaptls_out_buf.sv
rtl/eap_tls_fragment_reassembler.sv
bench/eap_tls_fragment_reassembler_test.sv
